[hw/rtl/rational_arithmetic_unit_macros.svh]
// Assertion macros for the rational arithmetic unit RTL.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RAU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rau_pkg.sv]
// Types, codes and constants of the rational arithmetic unit.
`default_nettype none
package rau_pkg;

    localparam int WORD_BITS = 32;
    localparam logic [63:0] LIM = (64'd1 << (WORD_BITS - 1)) - 64'd1;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_NEG   = 3'd4,
        OP_RECIP = 3'd5,
        OP_CMP   = 3'd6,
        OP_NORM  = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZDIV = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ORD_LT = 2'd0,
        ORD_EQ = 2'd1,
        ORD_GT = 2'd2
    } t_order;

    typedef enum logic [1:0] {
        MS_P1 = 2'd0,
        MS_P2 = 2'd1,
        MS_P3 = 2'd2
    } t_mslot;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_COMB,
        S_CHECK,
        S_GCD,
        S_DIVN,
        S_DIVN_W,
        S_DIVD,
        S_DIVD_W,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic   capture;
        logic   mul_en;
        t_mslot mul_sel;
        logic   combine;
        logic   gcd_step;
        logic   div_start;
        logic   div_den;
        logic   latch_q;
        logic   finish;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic is_cmp;
        logic zero;
        logic gcd_done;
        logic div_busy;
        logic div_done;
    } t_stat;

endpackage
`default_nettype wire

[hw/rtl/rational_arithmetic_unit.sv]
// Errors, compares and zero results pass through capture, the three products, combine, check,
// finish and the result strobe. Other operations add the binary GCD (one step per cycle, at most
// 128 steps) and two 64-bit divisions by the GCD.
// One transaction at a time: busy stays high until the result strobe cycle has ended.
// The result strobe lasts one cycle; the receiver cannot stall.
// Synchronous active-low reset returns the controller to idle; data registers are not reset.
`default_nettype none
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_a_num,
    input  logic [31:0] i_a_den,
    input  logic [31:0] i_b_num,
    input  logic [31:0] i_b_den,
    output logic        o_done,
    output logic [31:0] o_res_num,
    output logic [30:0] o_res_den,
    output logic [1:0]  o_order,
    output logic [1:0]  o_status
);

    t_cmd  w_cmd;
    t_stat w_stat;

    rau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    rau_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_operation (i_operation),
        .i_a_num     (i_a_num),
        .i_a_den     (i_a_den),
        .i_b_num     (i_b_num),
        .i_b_den     (i_b_den),
        .o_res_num   (o_res_num),
        .o_res_den   (o_res_den),
        .o_order     (o_order),
        .o_status    (o_status)
    );

endmodule
`default_nettype wire

[hw/rtl/rau_div.sv]
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
`default_nettype none
module rau_div
    import rau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_quo
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_dvs;

    logic [64:0] w_sh;
    logic [64:0] w_diff;
    logic        w_ge;

    assign w_sh   = {r_rem, r_quo[63]};
    assign w_ge   = w_sh >= {1'b0, r_dvs};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd0);
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd63;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[63:0] : w_sh[63:0];
            r_quo <= {r_quo[62:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

[hw/rtl/rau_datapath.sv]
// Datapath: operand registers, shared multiplier, combine step, binary GCD, divider and result.
`default_nettype none
module rau_datapath
    import rau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_a_num,
    input  logic [31:0] i_a_den,
    input  logic [31:0] i_b_num,
    input  logic [31:0] i_b_den,
    output logic [31:0] o_res_num,
    output logic [30:0] o_res_den,
    output logic [1:0]  o_order,
    output logic [1:0]  o_status
);

    t_op         r_op;
    logic        r_err;
    logic        r_an_neg;
    logic        r_bn_neg;
    logic [31:0] r_an;
    logic [31:0] r_ad;
    logic [31:0] r_bn;
    logic [31:0] r_bd;
    logic [63:0] r_p1;
    logic [63:0] r_p2;
    logic [63:0] r_p3;
    logic        r_rneg;
    logic [63:0] r_rnum;
    logic [63:0] r_rden;
    logic [63:0] r_x;
    logic [63:0] r_y;
    logic [5:0]  r_k;
    logic [63:0] r_qn;
    logic [63:0] r_qd;
    t_order      r_order;
    logic [31:0] r_res_num;
    logic [30:0] r_res_den;
    t_order      r_res_order;
    t_status     r_res_status;

    logic [31:0] n_res_num;
    logic [30:0] n_res_den;
    t_order      n_res_order;
    t_status     n_res_status;

    logic [31:0] w_an_mag;
    logic [31:0] w_ad_mag;
    logic [31:0] w_bn_mag;
    logic [31:0] w_bd_mag;
    logic        w_binary;
    logic        w_err;
    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_prod;
    logic        w_qneg;
    logic        w_cneg;
    logic [63:0] w_cnum;
    logic [63:0] w_cden;
    t_order      w_ord;
    logic [63:0] w_g;
    logic        w_ovf;
    logic        w_div_busy;
    logic        w_div_done;
    logic [63:0] w_quo;

    assign w_an_mag = i_a_num[31] ? 32'd0 - i_a_num : i_a_num;
    assign w_ad_mag = i_a_den[31] ? 32'd0 - i_a_den : i_a_den;
    assign w_bn_mag = i_b_num[31] ? 32'd0 - i_b_num : i_b_num;
    assign w_bd_mag = i_b_den[31] ? 32'd0 - i_b_den : i_b_den;

    assign w_binary = (t_op'(i_operation) == OP_ADD) || (t_op'(i_operation) == OP_SUB) ||
                      (t_op'(i_operation) == OP_MUL) || (t_op'(i_operation) == OP_DIV) ||
                      (t_op'(i_operation) == OP_CMP);
    assign w_err = (i_a_den == 32'd0) || (w_binary && (i_b_den == 32'd0)) ||
                   ((t_op'(i_operation) == OP_DIV) && (i_b_num == 32'd0)) ||
                   ((t_op'(i_operation) == OP_RECIP) && (i_a_num == 32'd0));

    // One 32x32 multiplier serves the three products in turn.
    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_P1: begin
                w_ma = r_an;
                w_mb = (r_op == OP_MUL) ? r_bn : r_bd;
            end
            MS_P2: begin
                w_ma = r_bn;
                w_mb = r_ad;
            end
            MS_P3: begin
                w_ma = r_ad;
                w_mb = (r_op == OP_DIV) ? r_bn : r_bd;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = {32'd0, w_ma} * {32'd0, w_mb};

    assign w_qneg = (r_op == OP_SUB) ? !r_bn_neg : r_bn_neg;

    always_comb begin
        w_cneg = 1'b0;
        w_cnum = r_p1;
        w_cden = r_p3;
        unique case (r_op)
            OP_ADD, OP_SUB: begin
                if (r_an_neg == w_qneg) begin
                    w_cneg = r_an_neg;
                    w_cnum = r_p1 + r_p2;
                end else if (r_p1 >= r_p2) begin
                    w_cneg = r_an_neg;
                    w_cnum = r_p1 - r_p2;
                end else begin
                    w_cneg = w_qneg;
                    w_cnum = r_p2 - r_p1;
                end
            end
            OP_MUL, OP_DIV: begin
                w_cneg = r_an_neg ^ r_bn_neg;
            end
            OP_NEG: begin
                w_cneg = !r_an_neg;
                w_cnum = {32'd0, r_an};
                w_cden = {32'd0, r_ad};
            end
            OP_RECIP: begin
                w_cneg = r_an_neg;
                w_cnum = {32'd0, r_ad};
                w_cden = {32'd0, r_an};
            end
            OP_CMP: begin
                w_cnum = 64'd0;
                w_cden = 64'd1;
            end
            OP_NORM: begin
                w_cneg = r_an_neg;
                w_cnum = {32'd0, r_an};
                w_cden = {32'd0, r_ad};
            end
            default: begin
                w_cnum = 64'd0;
                w_cden = 64'd1;
            end
        endcase
    end

    // A folded sign is only set on a nonzero magnitude, so the signs decide first.
    always_comb begin
        if (r_an_neg != r_bn_neg) begin
            w_ord = r_an_neg ? ORD_LT : ORD_GT;
        end else if (r_p1 == r_p2) begin
            w_ord = ORD_EQ;
        end else if (r_an_neg) begin
            w_ord = (r_p1 > r_p2) ? ORD_LT : ORD_GT;
        end else begin
            w_ord = (r_p1 > r_p2) ? ORD_GT : ORD_LT;
        end
    end

    assign w_g   = (r_x | r_y) << r_k;
    assign w_ovf = (r_qd > LIM) || (r_qn > (LIM + {63'd0, r_rneg}));

    always_comb begin
        n_res_num    = '0;
        n_res_den    = 31'd1;
        n_res_order  = ORD_LT;
        n_res_status = ST_OK;
        priority if (r_err) begin
            n_res_status = ST_ZDIV;
        end else if (r_op == OP_CMP) begin
            n_res_order = r_order;
        end else if (r_rnum == 64'd0) begin
            n_res_status = ST_OK;
        end else if (w_ovf) begin
            n_res_status = ST_OVF;
        end else begin
            n_res_num = r_rneg ? 32'd0 - r_qn[31:0] : r_qn[31:0];
            n_res_den = r_qd[30:0];
        end
    end

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (i_cmd.div_den ? r_rden : r_rnum),
        .i_divisor  (w_g),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quo      (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= t_op'(i_operation);
            r_err    <= w_err;
            r_an     <= w_an_mag;
            r_ad     <= w_ad_mag;
            r_bn     <= w_bn_mag;
            r_bd     <= w_bd_mag;
            r_an_neg <= (i_a_num[31] ^ i_a_den[31]) && (i_a_num != 32'd0);
            r_bn_neg <= (i_b_num[31] ^ i_b_den[31]) && (i_b_num != 32'd0);
        end
        if (i_cmd.mul_en) begin
            unique case (i_cmd.mul_sel)
                MS_P1:   r_p1 <= w_prod;
                MS_P2:   r_p2 <= w_prod;
                MS_P3:   r_p3 <= w_prod;
                default: r_p3 <= w_prod;
            endcase
        end
        if (i_cmd.combine) begin
            r_rneg  <= w_cneg;
            r_rnum  <= w_cnum;
            r_rden  <= w_cden;
            r_x     <= w_cnum;
            r_y     <= w_cden;
            r_k     <= '0;
            r_order <= (r_op == OP_CMP) ? w_ord : ORD_LT;
        end else if (i_cmd.gcd_step) begin
            priority if (!r_x[0] && !r_y[0]) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= r_k + 6'd1;
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (r_x >= r_y) begin
                r_x <= (r_x - r_y) >> 1;
            end else begin
                r_y <= (r_y - r_x) >> 1;
            end
        end
        if (i_cmd.latch_q) begin
            if (i_cmd.div_den) begin
                r_qd <= w_quo;
            end else begin
                r_qn <= w_quo;
            end
        end
        if (i_cmd.finish) begin
            r_res_num    <= n_res_num;
            r_res_den    <= n_res_den;
            r_res_order  <= n_res_order;
            r_res_status <= n_res_status;
        end
    end

    assign o_stat.err      = r_err;
    assign o_stat.is_cmp   = (r_op == OP_CMP);
    assign o_stat.zero     = (r_rnum == 64'd0);
    assign o_stat.gcd_done = (r_x == 64'd0) || (r_y == 64'd0);
    assign o_stat.div_busy = w_div_busy;
    assign o_stat.div_done = w_div_done;

    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_order   = r_res_order;
    assign o_status  = r_res_status;

endmodule
`default_nettype wire

[hw/rtl/rau_ctrl.sv]
// Controller state machine sequencing multiply, combine, GCD and the two divisions.
`default_nettype none
`include "rational_arithmetic_unit_macros.svh"
module rau_ctrl
    import rau_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_done
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_sel = MS_P1;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_P1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_P2;
                n_state = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_P3;
                n_state = S_COMB;
            end
            S_COMB: begin
                o_cmd.combine = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.err || i_stat.is_cmp || i_stat.zero) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (i_stat.gcd_done) begin
                    n_state = S_DIVN;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIVN: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIVN_W;
            end
            S_DIVN_W: begin
                if (i_stat.div_done) begin
                    o_cmd.latch_q = 1'b1;
                    n_state = S_DIVD;
                end
            end
            S_DIVD: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_den   = 1'b1;
                n_state = S_DIVD_W;
            end
            S_DIVD_W: begin
                o_cmd.div_den = 1'b1;
                if (i_stat.div_done) begin
                    o_cmd.latch_q = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_OUT);

    `RAU_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy, "busy not raised")
    `RAU_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, !o_busy, "busy after strobe")
    `RAU_ASSERT_NOW(a_gcd_live, i_clk, i_rst_n, o_cmd.gcd_step, !i_stat.gcd_done, "GCD overrun")
    `RAU_ASSERT_NOW(a_div_free, i_clk, i_rst_n, o_cmd.div_start, !i_stat.div_busy, "divider busy")

endmodule
`default_nettype wire
